// File: rtl/pcr_pkg.sv
`default_nettype none

package pcr_pkg;

    localparam int SETS         = 2048;
    localparam int WAYS         = 16;
    localparam int RECENCY_BITS = 24;

    localparam int SET_BITS  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LINE_BITS = SET_BITS + WAY_BITS;

    localparam int W_BITS     = 8;
    localparam int CODE_BITS  = 3;
    localparam int PROD_BITS  = W_BITS + RECENCY_BITS + 1;
    localparam int SCORE_BITS = PROD_BITS + 1;
    localparam int UPD_BITS   = ((RECENCY_BITS > W_BITS) ? RECENCY_BITS : W_BITS) + 2;
    localparam int LIMIT_BITS = 7;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 7'd10;
    localparam logic [32:0] REC_MAX = (33'd1 << RECENCY_BITS) - 33'd1;

    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam logic [1:0] KIND_LOAD     = 2'd0;
    localparam logic [1:0] KIND_WRITE    = 2'd1;
    localparam logic [1:0] KIND_PREFETCH = 2'd2;

    typedef logic signed [W_BITS-1:0]     t_weight;
    typedef logic signed [SCORE_BITS-1:0] t_score;
    typedef logic signed [CODE_BITS-1:0]  t_code;

    typedef struct packed {
        logic [31:0] last_use;
        t_weight     w2;
        t_weight     w1;
        t_weight     w0;
    } t_line;

    typedef struct packed {
        logic  valid;
        logic  hit;
        t_code code;
    } t_unit_ctl;

    function automatic t_code kind_code(input logic [1:0] kind);
        t_code c;
        case (kind)
            KIND_LOAD:     c = 3'sd1;
            KIND_WRITE:    c = 3'sd2;
            KIND_PREFETCH: c = -3'sd1;
            default:       c = 3'sd0;
        endcase
        return c;
    endfunction

    function automatic logic kind_ok(input logic [1:0] kind);
        return (kind == KIND_LOAD) || (kind == KIND_WRITE) || (kind == KIND_PREFETCH);
    endfunction

    function automatic t_weight clip(input logic signed [UPD_BITS-1:0] v,
                                     input logic [LIMIT_BITS-1:0] lim);
        logic signed [UPD_BITS-1:0] lim_s;
        logic signed [UPD_BITS-1:0] r;
        lim_s = $signed({{(UPD_BITS-LIMIT_BITS){1'b0}}, lim});
        if (v > lim_s) begin
            r = lim_s;
        end else if (v < -lim_s) begin
            r = -lim_s;
        end else begin
            r = v;
        end
        return W_BITS'(r);
    endfunction

endpackage

`default_nettype wire

// File: rtl/perceptron_cache_replacement.sv
// Channel   Dir  Handshake               Word
// request   in   i_valid / o_ready       opcode, set, way, access kind, hit, cycle
// result    out  o_valid / i_ready       victim way, error
// config    in   i_cfg_valid / o_cfg_ready  weight limit (7 bits)
//
// Victim search: one way read per cycle from the line RAM through the shared
// scoring unit. Update: read, recency, clip, write back. Unsupported kind or
// out-of-range way: straight to the result, no RAM access.
// After reset the line RAM is swept to zero, all 2^15 lines, one line a cycle; no
// request is taken meanwhile, config writes are. A pending result stalls the
// block only when the next result is ready to be handed over.
`default_nettype none

module perceptron_cache_replacement (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_opcode,
    input  logic [10:0]                    i_set_index,
    input  logic [3:0]                     i_way_index,
    input  logic [1:0]                     i_access_kind,
    input  logic                           i_hit,
    input  logic [31:0]                    i_cycle,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [3:0]                     o_victim_way,
    output logic                           o_error,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pcr_pkg::LIMIT_BITS-1:0] i_cfg_data
);
    import pcr_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_UPD_RD,
        S_UPD_WAIT,
        S_DONE
    } t_state;

    localparam logic [WAY_BITS-1:0]  WAY_LAST = WAY_BITS'(WAYS - 1);
    localparam logic [LINE_BITS-1:0] ADDR_LAST = '1;
    localparam logic [5:0]           WAYS_W   = 6'(WAYS);

    t_state                 r_state;
    logic [LIMIT_BITS-1:0]  r_limit;
    logic [LINE_BITS-1:0]   r_clr_addr;

    logic [SET_BITS-1:0]    r_set;
    logic [WAY_BITS-1:0]    r_way;
    logic                   r_hit;
    t_code                  r_code;
    logic [31:0]            r_now;

    logic [WAY_BITS-1:0]    r_rd_way;
    logic                   r_issue;
    logic                   r_rd_vld;
    logic [WAY_BITS-1:0]    r_cmp_way;
    logic [WAY_BITS-1:0]    r_best_way;
    t_score                 r_best_score;

    logic                   r_res_err;
    logic [3:0]             r_res_way;

    logic                   r_out_valid;
    logic [3:0]             r_out_way;
    logic                   r_out_err;

    logic                   w_accept;
    logic                   w_take_best;
    logic                   w_we;
    logic [LINE_BITS-1:0]   w_waddr;
    logic [LINE_BITS-1:0]   w_raddr;
    t_line                  w_wdata;
    t_line                  w_rdata;
    t_unit_ctl              w_ctl;
    logic                   u_valid;
    t_score                 u_score;
    t_line                  u_line;

    assign w_accept    = i_valid && o_ready;
    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign w_raddr = (r_state == S_SCAN) ? {r_set, r_rd_way} : {r_set, r_way};
    assign w_we    = (r_state == S_CLEAR) || ((r_state == S_UPD_WAIT) && u_valid);
    assign w_waddr = (r_state == S_CLEAR) ? r_clr_addr : {r_set, r_way};
    assign w_wdata = (r_state == S_CLEAR) ? '0 : u_line;

    assign w_ctl.valid = r_rd_vld;
    assign w_ctl.hit   = r_hit;
    assign w_ctl.code  = r_code;

    assign w_take_best = (r_cmp_way == '0) || (u_score < r_best_score);

    pcr_line_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pcr_score_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_line  (w_rdata),
        .i_now   (r_now),
        .i_limit (r_limit),
        .o_valid (u_valid),
        .o_score (u_score),
        .o_line  (u_line)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_limit     <= LIMIT_RESET;
            r_clr_addr  <= '0;
            r_issue     <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_cmp_way   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
            if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            r_rd_vld <= 1'b0;

            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_set     <= SET_BITS'(i_set_index);
                        r_way     <= WAY_BITS'(i_way_index);
                        r_hit     <= i_hit;
                        r_code    <= kind_code(i_access_kind);
                        r_now     <= i_cycle;
                        r_res_way <= '0;
                        r_res_err <= 1'b0;
                        r_rd_way  <= '0;
                        r_cmp_way <= '0;
                        if (!kind_ok(i_access_kind)) begin
                            r_res_err <= 1'b1;
                            r_state   <= S_DONE;
                        end else if (i_opcode == OP_VICTIM) begin
                            r_issue <= 1'b1;
                            r_state <= S_SCAN;
                        end else if ({2'b00, i_way_index} >= WAYS_W) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_UPD_RD;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_issue) begin
                        r_rd_vld <= 1'b1;
                        r_rd_way <= r_rd_way + 1'b1;
                        if (r_rd_way == WAY_LAST) begin
                            r_issue <= 1'b0;
                        end
                    end
                    if (u_valid) begin
                        r_cmp_way <= r_cmp_way + 1'b1;
                        if (w_take_best) begin
                            r_best_score <= u_score;
                            r_best_way   <= r_cmp_way;
                        end
                        if (r_cmp_way == WAY_LAST) begin
                            r_res_way <= w_take_best ? 4'(r_cmp_way) : 4'(r_best_way);
                            r_state   <= S_DONE;
                        end
                    end
                end
                S_UPD_RD: begin
                    r_rd_vld <= 1'b1;
                    r_state  <= S_UPD_WAIT;
                end
                S_UPD_WAIT: begin
                    if (u_valid) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_way   <= r_res_way;
                        r_out_err   <= r_res_err;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_victim_way = r_out_way;
    assign o_error      = r_out_err;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("request taken while busy");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !w_we)
        else $error("line RAM written during victim scan");

    a_unit_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u_valid |-> (r_state == S_SCAN) || (r_state == S_UPD_WAIT))
        else $error("scoring unit result outside a request");

    a_error_way_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_victim_way == 4'd0))
        else $error("error result with nonzero way");

endmodule

`default_nettype wire

// File: rtl/pcr_line_ram.sv
`default_nettype none

module pcr_line_ram (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [pcr_pkg::LINE_BITS-1:0]    i_waddr,
    input  pcr_pkg::t_line                   i_wdata,
    input  logic [pcr_pkg::LINE_BITS-1:0]    i_raddr,
    output pcr_pkg::t_line                   o_rdata
);
    import pcr_pkg::*;

    localparam int DEPTH = 1 << LINE_BITS;

    t_line r_mem [DEPTH];
    t_line r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/pcr_score_unit.sv
`default_nettype none

module pcr_score_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pcr_pkg::t_unit_ctl                i_ctl,
    input  pcr_pkg::t_line                    i_line,
    input  logic [31:0]                       i_now,
    input  logic [pcr_pkg::LIMIT_BITS-1:0]    i_limit,
    output logic                              o_valid,
    output pcr_pkg::t_score                   o_score,
    output pcr_pkg::t_line                    o_line
);
    import pcr_pkg::*;

    // stage 1: recency
    t_unit_ctl                 r_s1_ctl;
    logic [RECENCY_BITS-1:0]   r_s1_rec;
    t_weight                   r_s1_w0;
    t_weight                   r_s1_w1;
    t_weight                   r_s1_w2;
    logic [31:0]               r_s1_now;

    logic [31:0]               w_diff;
    logic [RECENCY_BITS-1:0]   w_rec;

    // stage 2: score / new weights
    logic                      r_s2_valid;
    t_score                    r_score;
    t_line                     r_line;

    logic signed [PROD_BITS-1:0]             w_prod;
    logic signed [W_BITS+CODE_BITS-1:0]      w_p0;
    t_score                                  w_score;
    logic signed [UPD_BITS-1:0]              w_f0;
    logic signed [UPD_BITS-1:0]              w_f1;
    logic signed [UPD_BITS-1:0]              w_f2;
    logic signed [UPD_BITS-1:0]              w_v0;
    logic signed [UPD_BITS-1:0]              w_v1;
    logic signed [UPD_BITS-1:0]              w_v2;

    always_comb begin
        w_diff = i_now - i_line.last_use;
        if ({1'b0, w_diff} > REC_MAX) begin
            w_rec = RECENCY_BITS'(REC_MAX);
        end else begin
            w_rec = RECENCY_BITS'(w_diff);
        end
    end

    always_comb begin
        w_prod  = $signed(r_s1_w1) * $signed({1'b0, r_s1_rec});
        w_p0    = $signed(r_s1_w0) * r_s1_ctl.code;
        w_score = SCORE_BITS'(w_prod) + SCORE_BITS'(w_p0) + SCORE_BITS'(r_s1_w2);

        w_f0 = UPD_BITS'(r_s1_ctl.code);
        w_f1 = $signed({{(UPD_BITS-RECENCY_BITS){1'b0}}, r_s1_rec});
        w_f2 = UPD_BITS'(2'sb01);
        if (r_s1_ctl.hit) begin
            w_v0 = UPD_BITS'(r_s1_w0) + w_f0;
            w_v1 = UPD_BITS'(r_s1_w1) + w_f1;
            w_v2 = UPD_BITS'(r_s1_w2) + w_f2;
        end else begin
            w_v0 = UPD_BITS'(r_s1_w0) - w_f0;
            w_v1 = UPD_BITS'(r_s1_w1) - w_f1;
            w_v2 = UPD_BITS'(r_s1_w2) - w_f2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl   <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_ctl   <= i_ctl;
            r_s2_valid <= r_s1_ctl.valid;
        end
        r_s1_rec <= w_rec;
        r_s1_w0  <= i_line.w0;
        r_s1_w1  <= i_line.w1;
        r_s1_w2  <= i_line.w2;
        r_s1_now <= i_now;

        r_score          <= w_score;
        r_line.w0        <= clip(w_v0, i_limit);
        r_line.w1        <= clip(w_v1, i_limit);
        r_line.w2        <= clip(w_v2, i_limit);
        r_line.last_use  <= r_s1_now;
    end

    assign o_valid = r_s2_valid;
    assign o_score = r_score;
    assign o_line  = r_line;

endmodule

`default_nettype wire
